>>> sv/circular_queue_engine_core_defines.svh
// ---------------------------------------------------------------------------
// Circular queue engine assertion macros
// Property wrappers used by the core to check this block.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_ENGINE_CORE_DEFINES_SVH
`define CIRCULAR_QUEUE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CQE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular queue engine check failed");

// next-cycle implication, disabled while in reset
`define CQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular queue engine check failed");

`endif

>>> sv/cqe_pkg.sv
// ---------------------------------------------------------------------------
// Circular queue engine package
// Field widths, operation and status codes, controller states and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
package cqe_pkg;

  localparam int CMD_W  = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_DISP = 2'd2
  } cqe_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } cqe_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_OUT
  } cqe_state_t;

  // controller -> datapath
  typedef struct packed {
    logic        enq;        // write value at tail, advance tail
    logic        deq;        // read at head, advance head or flush
    logic        walk_start; // walk pointer to head, read there
    logic        walk_step;  // advance walk pointer, read there
    logic        res_stat;   // load result: status only, last set
    logic        res_mem;    // load result from read data
    cqe_status_t stat;
    logic        rd_last;
  } cqe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic holds;
    logic full;
    logic walk_last;         // slot after walk pointer is the tail
  } cqe_sts_t;

endpackage

>>> sv/cqe_if.sv
// ---------------------------------------------------------------------------
// Circular queue engine channels
// Valid/ready interfaces for the command channel and the result channel.
// ---------------------------------------------------------------------------
interface cqe_in_if
  import cqe_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface cqe_out_if
  import cqe_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] data;
  logic                    last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

>>> sv/circular_queue_engine_core.sv
// ---------------------------------------------------------------------------
// Circular queue engine core
// Ring-buffer queue of signed words with programmable capacity.
// ---------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_ch     in   valid/ready       command, value
//  out_ch    out  valid/ready       status, data, last
//  cfg       in   cfg_we            cfg_wdata (capacity)
//
// One command transaction at a time. Enqueue and status-only results load the
// result register directly; a dequeue and each word of a display take a
// registered slot memory read before the result register is loaded.
// Output stalls hold the result register and the controller; no input is
// taken until the last result of a transaction has gone.
// Synchronous active-low reset; slot memory is not cleared.
module circular_queue_engine_core
  import cqe_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  cqe_in_if.sink           in_ch,
  cqe_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

`include "circular_queue_engine_core_defines.svh"

  cqe_cmd_t cmd;
  cqe_sts_t sts;
  logic     in_hs;

  assign in_hs = in_ch.valid && in_ch.ready;

  cqe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cqe_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_value   (in_ch.value),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (out_ch.status),
    .res_data   (out_ch.data),
    .res_last   (out_ch.last)
  );

  `CQE_ASSERT_NOW(a_no_accept_while_result, clk, rst_n, in_hs, !out_ch.valid)
  `CQE_ASSERT_NEXT(a_enq_gives_result, clk, rst_n, in_hs && in_ch.command == OP_ENQ, out_ch.valid)
  `CQE_ASSERT_NEXT(a_cfg_flushes, clk, rst_n, cfg_we, !sts.holds)
  `CQE_ASSERT_NOW(a_mid_result_ok, clk, rst_n, out_ch.valid && !out_ch.last, out_ch.status == ST_OK)

endmodule

>>> sv/cqe_ctrl.sv
// ---------------------------------------------------------------------------
// Circular queue engine controller
// Sequences one command transaction at a time and drives the datapath.
// ---------------------------------------------------------------------------
module cqe_ctrl
  import cqe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cqe_sts_t         sts,
  output cqe_cmd_t         cmd
);

  cqe_state_t state_r, state_nxt;
  logic       disp_r, disp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      disp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      disp_r  <= disp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    disp_nxt  = disp_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.stat  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_command)
            OP_ENQ: begin
              disp_nxt     = 1'b0;
              cmd.res_stat = 1'b1;
              if (sts.full) begin
                cmd.stat = ST_OVERFLOW;
              end else begin
                cmd.enq = 1'b1;
              end
              state_nxt = S_OUT;
            end
            OP_DEQ: begin
              disp_nxt = 1'b0;
              if (!sts.holds) begin
                cmd.res_stat = 1'b1;
                cmd.stat     = ST_UNDERFLOW;
                state_nxt    = S_OUT;
              end else begin
                cmd.deq   = 1'b1;
                state_nxt = S_RD;
              end
            end
            OP_DISP: begin
              // empty status is a single result, no walk follows
              disp_nxt = sts.holds;
              if (!sts.holds) begin
                cmd.res_stat = 1'b1;
                cmd.stat     = ST_EMPTY;
                state_nxt    = S_OUT;
              end else begin
                cmd.walk_start = 1'b1;
                state_nxt      = S_RD;
              end
            end
            default: ; // unused code: swallowed, no result
          endcase
        end
      end
      S_RD: begin
        cmd.res_mem = 1'b1;
        cmd.rd_last = !disp_r || sts.walk_last;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (disp_r && !sts.walk_last) begin
            cmd.walk_step = 1'b1;
            state_nxt     = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/cqe_dpath.sv
// ---------------------------------------------------------------------------
// Circular queue engine datapath
// Slot memory, head/tail/walk indices, capacity register, result register.
// ---------------------------------------------------------------------------
module cqe_dpath
  import cqe_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic signed [VAL_W-1:0]  in_value,
  input  cqe_cmd_t                 cmd,
  output cqe_sts_t                 sts,
  output logic [STAT_W-1:0]        res_status,
  output logic signed [VAL_W-1:0]  res_data,
  output logic                     res_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [VAL_W-1:0]      rd_ext;

  logic [CFG_W-1:0]  capacity_r;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [IW-1:0]     walk_r, walk_nxt;
  logic              holds_r, holds_nxt;
  logic [CW-1:0]     cap_eff;
  logic [IW-1:0]     head_inc, tail_inc, walk_inc;
  logic [IW-1:0]     rd_addr;
  logic              rd_en;

  logic [STAT_W-1:0]       status_r;
  logic signed [VAL_W-1:0] data_r;
  logic                    last_r;

  // written value of 0 acts as one slot, values above DEPTH as DEPTH
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity_r) > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(capacity_r);
    end
  end

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i,
                                              input logic [CW-1:0] cap);
    logic [IW-1:0] r;
    if ((32'(i) + 32'd1) >= 32'(cap)) begin
      r = '0;
    end else begin
      r = i + IW'(1);
    end
    return r;
  endfunction

  assign head_inc = next_slot(head_r, cap_eff);
  assign tail_inc = next_slot(tail_r, cap_eff);
  assign walk_inc = next_slot(walk_r, cap_eff);

  assign sts.holds     = holds_r;
  assign sts.full      = holds_r && (head_r == tail_r);
  assign sts.walk_last = (walk_inc == tail_r);

  // narrow: store keeps the low bits, read-out sign-extends; wide: store sign-extends, read-out keeps low bits
  generate
    if (DATA_WIDTH < VAL_W) begin : g_narrow
      assign wr_word = in_value[DATA_WIDTH-1:0];
      assign rd_ext  = {{(VAL_W-DATA_WIDTH){rd_data_r[DATA_WIDTH-1]}}, rd_data_r};
    end else if (DATA_WIDTH == VAL_W) begin : g_equal
      assign wr_word = in_value;
      assign rd_ext  = rd_data_r;
    end else begin : g_wide
      assign wr_word = {{(DATA_WIDTH-VAL_W){in_value[VAL_W-1]}}, in_value};
      assign rd_ext  = rd_data_r[VAL_W-1:0];
    end
  endgenerate

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    walk_nxt  = walk_r;
    holds_nxt = holds_r;
    if (cfg_we) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      holds_nxt = 1'b0;
    end else begin
      if (cmd.enq) begin
        tail_nxt  = tail_inc;
        holds_nxt = 1'b1;
      end
      if (cmd.deq) begin
        if (head_inc == tail_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          holds_nxt = 1'b0;
        end else begin
          head_nxt = head_inc;
        end
      end
      if (cmd.walk_start) begin
        walk_nxt = head_r;
      end else if (cmd.walk_step) begin
        walk_nxt = walk_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CFG_W'(16);
      head_r     <= '0;
      tail_r     <= '0;
      walk_r     <= '0;
      holds_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      walk_r  <= walk_nxt;
      holds_r <= holds_nxt;
    end
  end

  assign rd_en   = cmd.deq || cmd.walk_start || cmd.walk_step;
  assign rd_addr = cmd.walk_step ? walk_inc : head_r;

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      mem[tail_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_stat) begin
      status_r <= cmd.stat;
      data_r   <= '0;
      last_r   <= 1'b1;
    end else if (cmd.res_mem) begin
      status_r <= ST_OK;
      data_r   <= rd_ext;
      last_r   <= cmd.rd_last;
    end
  end

  assign res_status = status_r;
  assign res_data   = data_r;
  assign res_last   = last_r;

endmodule

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// Circular queue engine testbench
// Drives enqueue, dequeue and display commands through the valid/ready
// command channel with random gaps and output stalls, writes the capacity
// register between phases and checks every result against a queue predictor.
// ---------------------------------------------------------------------------
module testbench
  import cqe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 8;

  localparam logic [CMD_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    cqe_status_t        status;
    logic [VAL_W-1:0]   data;
    logic               last;
  } queue_result_t;

  // predictor and result store for the ring-buffer queue
  class queue_scoreboard;
    logic [VAL_W-1:0] slots [DEPTH];
    logic [3:0]       head;
    logic [3:0]       tail;
    bit               holds;
    logic [CFG_W-1:0] capacity;
    queue_result_t    expected_q [$];
    int               mismatches;

    function new();
      head       = '0;
      tail       = '0;
      holds      = 1'b0;
      capacity   = 5'd16;
      mismatches = 0;
    endfunction

    function void write_capacity(logic [CFG_W-1:0] v);
      capacity = v;
      head     = '0;
      tail     = '0;
      holds    = 1'b0;
    endfunction

    function int span();
      if (capacity == 0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return int'(capacity);
    endfunction

    function logic [3:0] advance(logic [3:0] i);
      int n;
      n = int'(i) + 1;
      return (n >= span()) ? 4'd0 : n[3:0];
    endfunction

    function void push(cqe_status_t st, logic [VAL_W-1:0] d, logic l);
      queue_result_t r;
      r.status = st;
      r.data   = d;
      r.last   = l;
      expected_q.push_back(r);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v);
      logic [3:0] i;
      int         n;
      case (cmd)
        OP_ENQ: begin
          if (holds && tail == head) begin
            push(ST_OVERFLOW, '0, 1'b1);
          end else begin
            slots[tail] = v;
            tail        = advance(tail);
            holds       = 1'b1;
            push(ST_OK, '0, 1'b1);
          end
        end
        OP_DEQ: begin
          if (!holds) begin
            push(ST_UNDERFLOW, '0, 1'b1);
          end else begin
            push(ST_OK, slots[head], 1'b1);
            head = advance(head);
            if (head == tail) begin
              head  = '0;
              tail  = '0;
              holds = 1'b0;
            end
          end
        end
        OP_DISP: begin
          if (!holds) begin
            push(ST_EMPTY, '0, 1'b1);
          end else begin
            i = head;
            n = 0;
            do begin
              push(ST_OK, slots[i], 1'b0);
              n++;
              i = advance(i);
            end while (i != tail && n < DEPTH);
            expected_q[expected_q.size()-1].last = 1'b1;
          end
        end
        default: ; // unknown command: no effect, no result
      endcase
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] d, logic l);
      queue_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %h last %0b", st, d, l);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || d !== e.data || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, data exp %h got %h, last exp %0b got %0b",
                   e.status, st, e.data, d, e.last, l);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               calm;
  int               idle_cycles;

  cqe_in_if  in_ch ();
  cqe_out_if out_ch ();

  queue_scoreboard sb = new();

  circular_queue_engine_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // note inputs before checking results so the store is always up to date
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_capacity(cfg_wdata);
      if (in_ch.valid && in_ch.ready) sb.note_command(in_ch.command, in_ch.value);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.data, out_ch.last);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure
  initial begin
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait for every expected result, then let any result-free command finish
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_command(int enq_pct, int deq_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return OP_ENQ;
    if (r < enq_pct + deq_pct) return OP_DEQ;
    if (r < 95) return OP_DISP;
    return OP_UNKNOWN;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  initial begin
    int caps [9];
    int eff;
    int fill_len;
    int phase_len;
    logic [CMD_W-1:0] cmd;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = OP_ENQ;
    in_ch.value   = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    idle_cycles   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, unknown command, extreme words, full at one slot
    send_item(OP_DISP, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_UNKNOWN, 32'hffff_ffff);
    send_item(OP_ENQ, 32'h7fff_ffff);
    send_item(OP_ENQ, 32'h8000_0000);
    send_item(OP_ENQ, 32'h0000_0000);
    send_item(OP_ENQ, 32'hffff_ffff);
    send_item(OP_UNKNOWN, '0);
    send_item(OP_DISP, '0);
    repeat (4) send_item(OP_DEQ, '0);
    send_item(OP_DEQ, '0);
    write_capacity(5'd1);
    send_item(OP_ENQ, 32'h1234_5678);
    send_item(OP_ENQ, 32'h5555_aaaa);
    send_item(OP_DISP, '0);
    send_item(OP_DEQ, '0);
    // zero capacity behaves as one slot
    write_capacity(5'd0);
    send_item(OP_ENQ, 32'haaaa_5555);
    send_item(OP_ENQ, 32'h0000_0001);
    send_item(OP_DISP, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_DISP, '0);

    caps = '{16, 31, 2, 17, 0, 1, 7, 12, 16};
    caps[6] = $urandom_range(3, 15);
    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p][CFG_W-1:0]);
      calm = (p == 1) || ($urandom_range(0, 3) == 0);
      eff  = (caps[p] == 0) ? 1 : (caps[p] > DEPTH) ? DEPTH : caps[p];
      fill_len  = eff + 2;
      phase_len = 2 * eff + 8;
      for (int k = 0; k < phase_len; k++) begin
        if (p == 3 && k == fill_len) begin
          // hold off the sender until the queue has answered everything
          @(negedge clk);
          in_ch.valid <= 1'b0;
          wait_drained();
        end
        if (k < fill_len)
          cmd = pick_command(85, 5);
        else if (k < fill_len + 8)
          cmd = pick_command(40, 40);
        else
          cmd = pick_command(5, 80);
        send_item(cmd, pick_value());
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/cqe_pkg.sv
sv/cqe_if.sv
sv/cqe_ctrl.sv
sv/cqe_dpath.sv
sv/circular_queue_engine_core.sv
test/testbench.sv
